[design/tklc_pkg.sv]
// Shared types and constants for the trajectory kinematic limit checker.
// No dependencies; imported by every module of the block.
package tklc_pkg;

  // One trajectory point as it enters the block.
  typedef struct packed {
    logic signed [31:0] rel_time;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic signed [31:0] curvature;
    logic               last_point;
  } tklc_in_t;

  // One trajectory verdict.
  typedef struct packed {
    logic       trajectory_ok;
    logic [5:0] violation_mask;
  } tklc_out_t;

  localparam int MASK_W = 6;

  // Violation mask bit positions
  localparam int V_SPEED     = 0;
  localparam int V_LON_ACCEL = 1;
  localparam int V_CURVATURE = 2;
  localparam int V_LON_JERK  = 3;
  localparam int V_LAT_ACCEL = 4;
  localparam int V_LAT_JERK  = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LON_ACCEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LON_JERK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVATURE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_ACCEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_JERK  = 3'd6;

  // Differences of two Q16.16 values carry one extra bit.
  localparam int DIFF_W = 33;
  localparam int Q_W    = 32;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] dividend;
    logic [DIFF_W-1:0] divisor;
  } tklc_div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
  } tklc_div_rsp_t;

endpackage

[design/tklc_div.sv]
// Bit-serial signed rate divider: (diff * 65536) / dt, truncated, saturated to 32 bits.
// Depends on tklc_pkg for the request and response structs.
module tklc_div import tklc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  tklc_div_req_t req,
  output tklc_div_rsp_t rsp
);

  localparam int DivSteps = DIFF_W + 16;
  localparam int CntW     = $clog2(DivSteps);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_SAT  = 2'd2;

  logic [1:0]          st_r;
  logic [CntW-1:0]     cnt_r;
  logic [DIFF_W:0]     rem_r;
  logic [DivSteps-1:0] quo_r;
  logic [DIFF_W-1:0]   dsr_r;
  logic                neg_r;
  logic                done_r;
  logic [Q_W-1:0]      q_r;

  logic [DIFF_W-1:0] num_mag;
  logic [DIFF_W-1:0] den_mag;
  logic [DIFF_W:0]   shl;
  logic [DIFF_W+1:0] trial;
  logic              fit;
  logic              pos_big;
  logic              neg_big;
  logic [Q_W-1:0]    q_nxt;

  always_comb begin
    num_mag = req.dividend[DIFF_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    den_mag = req.divisor[DIFF_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;
    shl     = {rem_r[DIFF_W-1:0], quo_r[DivSteps-1]};
    trial   = {1'b0, shl} - {2'b00, dsr_r};
    fit     = ~trial[DIFF_W+1];
    pos_big = |quo_r[DivSteps-1:Q_W-1];
    neg_big = (|quo_r[DivSteps-1:Q_W]) | (quo_r[Q_W-1] & (|quo_r[Q_W-2:0]));
    if (neg_r) begin
      q_nxt = neg_big ? {1'b1, {(Q_W-1){1'b0}}} : (~quo_r[Q_W-1:0] + 1'b1);
    end else begin
      q_nxt = pos_big ? {1'b0, {(Q_W-1){1'b1}}} : quo_r[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == D_SAT);
      unique case (st_r)
        D_IDLE: begin
          if (req.start) begin
            rem_r <= '0;
            quo_r <= {num_mag, 16'b0};
            dsr_r <= den_mag;
            neg_r <= req.dividend[DIFF_W-1] ^ req.divisor[DIFF_W-1];
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= fit ? trial[DIFF_W:0] : shl;
          quo_r <= {quo_r[DivSteps-2:0], fit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(DivSteps - 1)) begin
            st_r <= D_SAT;
          end
        end
        D_SAT: begin
          q_r  <= q_nxt;
          st_r <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

[design/trajectory_kinematic_limit_checker.sv]
// Top level of the trajectory kinematic limit checker: sequencer, serial multiplier, checks.
// Depends on tklc_pkg and instantiates tklc_div.
//
// The block takes one trajectory point per request and, on a point marked last_point, gives
// one verdict request: trajectory_ok and a six-bit violation_mask (speed, lon accel,
// curvature, lon jerk, lat accel, lat jerk). The first point whose rel_time exceeds
// horizon_time and all points after it are skipped until the trajectory ends. One point is
// worked at a time; in_stall is high from the cycle after acceptance until the point is
// finished. A point past the horizon goes from the horizon check straight to the finish
// state. A checked point runs the bit-serial multiplier (32 steps for v*v, 32 for
// v*v*|kappa|); a checked later point then makes two passes of the shared bit-serial
// divider, for longitudinal and lateral jerk; a zero dt skips the divider. A last point
// adds an output state to post the verdict, and waits there while a previous verdict is
// still held by out_stall. Configuration writes are always ready and must only be issued
// while the block is idle.
module trajectory_kinematic_limit_checker import tklc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tklc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tklc_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int MulSteps = 32;
  localparam int MulCntW  = $clog2(MulSteps);
  localparam int McandW   = 64;
  localparam int ProdW    = McandW + MulSteps;
  localparam int MagLsb   = 40;

  localparam logic [31:0] HorizonRst = 32'd524288;
  localparam logic [30:0] CurvRst    = 31'd3355443;
  localparam logic [30:0] LatRst     = 31'd262144;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HZN  = 4'd1;
  localparam logic [3:0] S_SQR  = 4'd2;
  localparam logic [3:0] S_KMUL = 4'd3;
  localparam logic [3:0] S_LAT  = 4'd4;
  localparam logic [3:0] S_PAIR = 4'd5;
  localparam logic [3:0] S_LJRK = 4'd6;
  localparam logic [3:0] S_TJRK = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // lower <= v <= upper, both bounds signed in one 64-bit word
  function automatic logic in_pair(logic signed [31:0] v, logic [63:0] lim);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = lim[31:0];
    hi = lim[63:32];
    return (lo <= v) && (v <= hi);
  endfunction

  // -b <= v <= b with an unsigned 31-bit magnitude bound
  function automatic logic in_sym(logic signed [31:0] v, logic [30:0] b);
    logic signed [32:0] vs;
    logic signed [32:0] bs;
    vs = {v[31], v};
    bs = {2'b00, b};
    return (vs <= bs) && (vs >= -bs);
  endfunction

  // Configuration registers
  logic signed [31:0] horizon_r;
  logic [63:0]        speed_lim_r;
  logic [63:0]        accel_lim_r;
  logic [63:0]        ljerk_lim_r;
  logic [30:0]        curv_bnd_r;
  logic [30:0]        lat_bnd_r;
  logic [30:0]        tjerk_bnd_r;

  // Sequencer and trajectory history
  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic signed [31:0] prev_time_r;
  logic signed [31:0] prev_accel_r;
  logic signed [31:0] prev_lat_r;
  logic               have_prev_r;
  logic               past_hz_r;
  logic [MASK_W-1:0]  viol_r;

  // Current point
  logic signed [31:0] t_r;
  logic signed [31:0] v_r;
  logic signed [31:0] a_r;
  logic signed [31:0] k_r;
  logic               last_r;
  logic               chk_r;
  logic [MASK_W-1:0]  mask_r;
  logic [DIFF_W-1:0]  dt_r;
  logic [DIFF_W-1:0]  dla_r;
  logic [DIFF_W-1:0]  dlat_r;
  logic signed [31:0] lat_r;

  // Serial multiplier
  logic [McandW-1:0]  mcand_r;
  logic [ProdW-1:0]   prod_r;
  logic [MulCntW-1:0] cnt_r;
  logic [McandW:0]    psum;
  logic [ProdW-1:0]   prod_nxt;

  // Output register
  logic               out_valid_r;
  tklc_out_t          out_r;

  logic               over_hz;
  logic [31:0]        av;
  logic [31:0]        ak;
  logic [ProdW-MagLsb-1:0] mag;
  logic [31:0]        lat_nxt;
  logic [MASK_W-1:0]  pt_mask;
  logic [MASK_W-1:0]  pair_mask;
  logic               slot_free;
  logic               in_acc;

  tklc_div_req_t      div_req;
  tklc_div_rsp_t      div_rsp;

  assign in_acc    = in_valid & ~in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = ~out_valid_r | ~out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    over_hz  = past_hz_r | (t_r > horizon_r);
    av       = v_r[31] ? (~v_r + 32'd1) : v_r;
    ak       = k_r[31] ? (~k_r + 32'd1) : k_r;
    // shift-add step: add multiplicand when the low multiplier bit is set, shift right
    psum     = {1'b0, prod_r[ProdW-1:MulSteps]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {psum, prod_r[MulSteps-1:1]};
    // v*v*|kappa| >> 40, signed like kappa and saturated
    mag      = prod_r[ProdW-1:MagLsb];
    if (k_r[31]) begin
      lat_nxt = (mag > (ProdW-MagLsb)'(64'd2147483648)) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      lat_nxt = (mag > (ProdW-MagLsb)'(64'd2147483647)) ? 32'h7FFF_FFFF : mag[31:0];
    end
    // range checks of the point itself
    pt_mask              = '0;
    pt_mask[V_SPEED]     = ~in_pair(v_r, speed_lim_r);
    pt_mask[V_LON_ACCEL] = ~in_pair(a_r, accel_lim_r);
    pt_mask[V_CURVATURE] = ~in_sym(k_r, curv_bnd_r);
    // pair checks that need no division
    pair_mask = mask_r;
    if (!in_sym(lat_r, lat_bnd_r)) begin
      pair_mask[V_LAT_ACCEL] = 1'b1;
    end
    if (dt_r == '0) begin
      pair_mask[V_LON_JERK] = 1'b1;
      pair_mask[V_LAT_JERK] = 1'b1;
    end
  end

  // Divider requests: lon jerk from the pair state, lat jerk once lon jerk is back
  assign div_req.start    = ((state_r == S_PAIR) && (dt_r != '0))
                          | ((state_r == S_LJRK) && div_rsp.done);
  assign div_req.dividend = (state_r == S_PAIR) ? dla_r : dlat_r;
  assign div_req.divisor  = dt_r;

  tklc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_HZN;
      S_HZN:  state_nxt = over_hz ? S_FIN : S_SQR;
      S_SQR:  if (cnt_r == MulCntW'(MulSteps - 1)) state_nxt = S_KMUL;
      S_KMUL: if (cnt_r == MulCntW'(MulSteps - 1)) state_nxt = S_LAT;
      S_LAT:  state_nxt = have_prev_r ? S_PAIR : S_FIN;
      S_PAIR: state_nxt = (dt_r == '0) ? S_FIN : S_LJRK;
      S_LJRK: if (div_rsp.done) state_nxt = S_TJRK;
      S_TJRK: if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:  state_nxt = last_r ? S_OUT : S_IDLE;
      S_OUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r   <= HorizonRst;
      speed_lim_r <= '0;
      accel_lim_r <= '0;
      ljerk_lim_r <= '0;
      curv_bnd_r  <= CurvRst;
      lat_bnd_r   <= LatRst;
      tjerk_bnd_r <= LatRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HORIZON:   horizon_r   <= cfg_data[31:0];
        CFG_SPEED:     speed_lim_r <= cfg_data;
        CFG_LON_ACCEL: accel_lim_r <= cfg_data;
        CFG_LON_JERK:  ljerk_lim_r <= cfg_data;
        CFG_CURVATURE: curv_bnd_r  <= cfg_data[30:0];
        CFG_LAT_ACCEL: lat_bnd_r   <= cfg_data[30:0];
        CFG_LAT_JERK:  tjerk_bnd_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer, history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      have_prev_r  <= 1'b0;
      past_hz_r    <= 1'b0;
      viol_r       <= '0;
      prev_time_r  <= '0;
      prev_accel_r <= '0;
      prev_lat_r   <= '0;
    end else begin
      state_r <= state_nxt;
      // post a verdict when the slot frees up; drop it once it is taken
      if (state_r == S_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            t_r    <= in_data.rel_time;
            v_r    <= in_data.speed;
            a_r    <= in_data.accel;
            k_r    <= in_data.curvature;
            last_r <= in_data.last_point;
          end
        end
        S_HZN: begin
          chk_r     <= ~over_hz;
          past_hz_r <= over_hz;
          dt_r      <= {t_r[31], t_r} - {prev_time_r[31], prev_time_r};
          dla_r     <= {a_r[31], a_r} - {prev_accel_r[31], prev_accel_r};
          mask_r    <= pt_mask;
          // load |v| * |v|
          mcand_r <= {{(McandW-32){1'b0}}, av};
          prod_r  <= {{(ProdW-32){1'b0}}, av};
          cnt_r   <= '0;
        end
        S_SQR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == MulCntW'(MulSteps - 1)) begin
            // v*v becomes the multiplicand, |kappa| the multiplier
            mcand_r <= prod_nxt[McandW-1:0];
            prod_r  <= {{(ProdW-32){1'b0}}, ak};
          end else begin
            prod_r <= prod_nxt;
          end
        end
        S_KMUL: begin
          cnt_r  <= cnt_r + 1'b1;
          prod_r <= prod_nxt;
        end
        S_LAT: begin
          lat_r <= lat_nxt;
        end
        S_PAIR: begin
          dlat_r <= {lat_r[31], lat_r} - {prev_lat_r[31], prev_lat_r};
          mask_r <= pair_mask;
        end
        S_LJRK: begin
          if (div_rsp.done && !in_pair(div_rsp.quotient, ljerk_lim_r)) begin
            mask_r[V_LON_JERK] <= 1'b1;
          end
        end
        S_TJRK: begin
          if (div_rsp.done && !in_sym(div_rsp.quotient, tjerk_bnd_r)) begin
            mask_r[V_LAT_JERK] <= 1'b1;
          end
        end
        S_FIN: begin
          // commit a checked point to the history
          if (chk_r) begin
            viol_r       <= viol_r | mask_r;
            prev_time_r  <= t_r;
            prev_accel_r <= a_r;
            prev_lat_r   <= lat_r;
            have_prev_r  <= 1'b1;
          end
        end
        S_OUT: begin
          // post the verdict and start a fresh trajectory
          if (slot_free) begin
            out_r.trajectory_ok  <= (viol_r == '0);
            out_r.violation_mask <= viol_r;
            viol_r               <= '0;
            have_prev_r          <= 1'b0;
            past_hz_r            <= 1'b0;
            prev_time_r          <= '0;
            prev_accel_r         <= '0;
            prev_lat_r           <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/tklc_checker.sv]
// Port-level checks for the trajectory kinematic limit checker, bound to the top level.
// Depends on tklc_pkg for the result struct.
module tklc_checker import tklc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input tklc_out_t out_data
);

  // hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled verdict changed or vanished");

  a_ok_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.trajectory_ok == (out_data.violation_mask == '0)))
    else $error("pass bit disagrees with violation mask");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but block did not go busy");

  a_verdict_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("verdict posted without a point in work");

endmodule

bind trajectory_kinematic_limit_checker tklc_checker u_tklc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[test/tklc_verdict_check.sv]
`timescale 1ns / 1ps
// Passive checker for the trajectory kinematic limit checker: watches the point, verdict and
// register write channels, computes the expected verdicts and compares them. Uses tklc_pkg.
module tklc_verdict_check import tklc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  tklc_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  tklc_out_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   fails,
  output int                   pending,
  output int                   verdicts,
  output int                   passes
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // Register copies
  logic [31:0] horizon_reg;
  logic [63:0] speed_lim;
  logic [63:0] accel_lim;
  logic [63:0] jerk_lim;
  logic [30:0] curv_bnd;
  logic [30:0] lat_acc_bnd;
  logic [30:0] lat_jerk_bnd;

  // Trajectory history
  logic signed [31:0] last_t;
  logic signed [31:0] last_a;
  logic signed [31:0] last_lat;
  logic               have_last;
  logic               beyond_hz;
  logic [5:0]         viol_acc;

  tklc_out_t verdict_q[$];
  tklc_out_t want;
  bit        wrong;

  function automatic longint sat_q(longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  function automatic longint jerk_of(longint diff, longint dt);
    return sat_q((diff * 65536) / dt);
  endfunction

  function automatic bit within_pair(longint x, logic [63:0] lim);
    longint lo, hi;
    lo = $signed(lim[31:0]);
    hi = $signed(lim[63:32]);
    return (lo <= x) && (x <= hi);
  endfunction

  function automatic bit within_mag(longint x, logic [30:0] b);
    longint m;
    m = longint'({33'b0, b});
    return (-m <= x) && (x <= m);
  endfunction

  // v*v*|kappa| >> 40 on magnitudes, then signed like kappa and saturated
  function automatic longint lateral_of(longint v, longint k);
    logic [63:0] av, ak, v2;
    logic [95:0] prod, mag;
    av = (v < 0) ? 64'(-v) : 64'(v);
    ak = (k < 0) ? 64'(-k) : 64'(k);
    v2 = av * av;
    prod = {32'b0, v2} * {32'b0, ak};
    mag = prod >> 40;
    if (k < 0) return (mag > 96'd2147483648) ? Q_MIN : -longint'(mag[63:0]);
    return (mag > 96'd2147483647) ? Q_MAX : longint'(mag[63:0]);
  endfunction

  function automatic void clear_history();
    last_t    = '0;
    last_a    = '0;
    last_lat  = '0;
    have_last = 1'b0;
    beyond_hz = 1'b0;
    viol_acc  = '0;
  endfunction

  function automatic void take_point(tklc_in_t p);
    longint t, v, a, k, dt, lat;
    logic [5:0] m;
    tklc_out_t r;
    t = $signed(p.rel_time);
    v = $signed(p.speed);
    a = $signed(p.accel);
    k = $signed(p.curvature);
    if (!beyond_hz && t > longint'($signed(horizon_reg))) beyond_hz = 1'b1;
    if (!beyond_hz) begin
      m = '0;
      lat = lateral_of(v, k);
      if (!within_pair(v, speed_lim)) m[V_SPEED] = 1'b1;
      if (!within_pair(a, accel_lim)) m[V_LON_ACCEL] = 1'b1;
      if (!within_mag(k, curv_bnd)) m[V_CURVATURE] = 1'b1;
      if (have_last) begin
        dt = t - longint'(last_t);
        if (dt == 0) begin
          m[V_LON_JERK] = 1'b1;
          m[V_LAT_JERK] = 1'b1;
        end else begin
          if (!within_pair(jerk_of(a - longint'(last_a), dt), jerk_lim))
            m[V_LON_JERK] = 1'b1;
          if (!within_mag(jerk_of(lat - longint'(last_lat), dt), lat_jerk_bnd))
            m[V_LAT_JERK] = 1'b1;
        end
        if (!within_mag(lat, lat_acc_bnd)) m[V_LAT_ACCEL] = 1'b1;
      end
      viol_acc  = viol_acc | m;
      last_t    = t[31:0];
      last_a    = a[31:0];
      last_lat  = lat[31:0];
      have_last = 1'b1;
    end
    if (p.last_point) begin
      r.trajectory_ok  = (viol_acc == '0);
      r.violation_mask = viol_acc;
      verdict_q.push_back(r);
      clear_history();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      horizon_reg  = 32'd524288;
      speed_lim    = '0;
      accel_lim    = '0;
      jerk_lim     = '0;
      curv_bnd     = 31'd3355443;
      lat_acc_bnd  = 31'd262144;
      lat_jerk_bnd = 31'd262144;
      clear_history();
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict ok=%b mask=%b, none outstanding",
                   $time, out_data.trajectory_ok, out_data.violation_mask);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          wrong = 1'b0;
          if (out_data.trajectory_ok !== want.trajectory_ok) begin
            $display("%0t: trajectory_ok expected %b actual %b",
                     $time, want.trajectory_ok, out_data.trajectory_ok);
            wrong = 1'b1;
          end
          if (out_data.violation_mask !== want.violation_mask) begin
            $display("%0t: violation_mask expected %b actual %b",
                     $time, want.violation_mask, out_data.violation_mask);
            wrong = 1'b1;
          end
          if (wrong) fails++;
          if (want.trajectory_ok) passes++;
        end
        verdicts++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HORIZON:   horizon_reg  = cfg_data[31:0];
          CFG_SPEED:     speed_lim    = cfg_data;
          CFG_LON_ACCEL: accel_lim    = cfg_data;
          CFG_LON_JERK:  jerk_lim     = cfg_data;
          CFG_CURVATURE: curv_bnd     = cfg_data[30:0];
          CFG_LAT_ACCEL: lat_acc_bnd  = cfg_data[30:0];
          CFG_LAT_JERK:  lat_jerk_bnd = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_point(in_data);
    end
    pending = verdict_q.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the trajectory kinematic limit checker testbench: clock, reset, point and register
// stimulus, receiver stalls and the verdict. Needs tklc_pkg, the block and tklc_verdict_check.
module tb_top;
  import tklc_pkg::*;

  localparam int Q16          = 65536;
  localparam int S_MAX        = 32'h7FFF_FFFF;
  localparam int S_MIN        = -S_MAX - 1;
  localparam int CURV_TYP     = 3355443;      // 0.2 per metre in Q8.24
  localparam int DRAIN_CYCLES = 250;          // longer than the longest point
  localparam int HOLD_CYCLES  = 1500;
  localparam int SEG_POINTS   = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {SET_TYPICAL, SET_WIDE, SET_RANDOM, SET_STRICT} cfg_set_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  tklc_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  tklc_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  int mismatch_cnt;
  int open_verdicts;
  int verdict_cnt;
  int pass_cnt;

  // Stimulus bookkeeping
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_req;
  int points_sent;
  int cfg_writes;
  int cur_horizon;
  cfg_set_t seg_cfg [6] = '{SET_TYPICAL, SET_RANDOM, SET_WIDE,
                            SET_TYPICAL, SET_RANDOM, SET_TYPICAL};

  trajectory_kinematic_limit_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tklc_verdict_check CHK (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (mismatch_cnt),
    .pending   (open_verdicts),
    .verdicts  (verdict_cnt),
    .passes    (pass_cnt)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop.
  initial begin
    #4_000_000;
    $display("Timeout with %0d verdicts outstanding", open_verdicts);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: drive out_stall at each falling edge. A hold-off request from the stimulus
  // loads a long stall counted here; otherwise stall at the current random rate.
  initial begin
    int held;
    int seen_req;
    held = 0;
    seen_req = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        held = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  function automatic int srand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic tklc_in_t mk_point(int t, int v, int a, int k, bit last);
    tklc_in_t p;
    p.rel_time   = t;
    p.speed      = v;
    p.accel      = a;
    p.curvature  = k;
    p.last_point = last;
    return p;
  endfunction

  function automatic logic [63:0] pair(int lo, int hi);
    return {hi[31:0], lo[31:0]};
  endfunction

  // Bound with random junk above bit 30, which the block must drop.
  function automatic logic [63:0] dirty(logic [30:0] b);
    return {32'($urandom), 1'($urandom_range(1)), b};
  endfunction

  function automatic logic [63:0] rnd_pair();
    case ($urandom_range(3))
      0: return {32'($urandom), 32'($urandom)};
      1: return pair(-srand(0, 10 * Q16), srand(Q16, 50 * Q16));
      2: return 64'h0;
      default: return pair(S_MIN, S_MAX);
    endcase
  endfunction

  function automatic logic [30:0] rnd_bound();
    case ($urandom_range(3))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      default: return 31'(srand(Q16, 8 * Q16));
    endcase
  endfunction

  // Offer one point; idle first at the sender's rate, then hold it until accepted.
  // Returns at the falling edge after acceptance with in_valid still high.
  task automatic send_point(input tklc_in_t p);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = p;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  // Drop the request and wait for every outstanding verdict.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (open_verdicts != 0) @(negedge clk);
  endtask

  // Drain, then let a point that produces no verdict finish before touching registers.
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Write all seven registers for one setting; call only with the block idle.
  task automatic load_config(input cfg_set_t kind);
    case (kind)
      SET_TYPICAL: begin
        cur_horizon = srand(3, 10) * Q16;
        cfg_write(CFG_HORIZON, {32'($urandom), cur_horizon[31:0]});
        cfg_write(CFG_SPEED, pair(0, 40 * Q16));
        cfg_write(CFG_LON_ACCEL, pair(-6 * Q16, 4 * Q16));
        cfg_write(CFG_LON_JERK, pair(-4 * Q16, 2 * Q16));
        cfg_write(CFG_CURVATURE, dirty(31'(CURV_TYP)));
        cfg_write(CFG_LAT_ACCEL, dirty(31'(4 * Q16)));
        cfg_write(CFG_LAT_JERK, dirty(31'(4 * Q16)));
      end
      SET_WIDE: begin
        cur_horizon = S_MAX;
        cfg_write(CFG_HORIZON, {32'($urandom), cur_horizon[31:0]});
        cfg_write(CFG_SPEED, pair(S_MIN, S_MAX));
        cfg_write(CFG_LON_ACCEL, pair(S_MIN, S_MAX));
        cfg_write(CFG_LON_JERK, pair(S_MIN, S_MAX));
        cfg_write(CFG_CURVATURE, dirty(31'h7FFF_FFFF));
        cfg_write(CFG_LAT_ACCEL, dirty(31'h7FFF_FFFF));
        cfg_write(CFG_LAT_JERK, dirty(31'h7FFF_FFFF));
      end
      SET_RANDOM: begin
        case ($urandom_range(3))
          0: cur_horizon = S_MIN;
          1: cur_horizon = S_MAX;
          2: cur_horizon = $urandom;
          default: cur_horizon = srand(2, 10) * Q16;
        endcase
        cfg_write(CFG_HORIZON, {32'($urandom), cur_horizon[31:0]});
        cfg_write(CFG_SPEED, rnd_pair());
        cfg_write(CFG_LON_ACCEL, rnd_pair());
        cfg_write(CFG_LON_JERK, rnd_pair());
        cfg_write(CFG_CURVATURE, dirty(rnd_bound()));
        cfg_write(CFG_LAT_ACCEL, dirty(rnd_bound()));
        cfg_write(CFG_LAT_JERK, dirty(rnd_bound()));
      end
      default: begin
        // Reversed pairs and zero bounds; also poke the unused index, which must do nothing.
        cur_horizon = 0;
        cfg_write(CFG_HORIZON, {32'($urandom), 32'h0});
        cfg_write(CFG_SPEED, pair(10 * Q16, 5 * Q16));
        cfg_write(CFG_LON_ACCEL, 64'h0);
        cfg_write(CFG_LON_JERK, pair(S_MAX, S_MIN));
        cfg_write(CFG_CURVATURE, dirty('0));
        cfg_write(CFG_LAT_ACCEL, dirty('0));
        cfg_write(CFG_LAT_JERK, dirty('0));
        cfg_write(CFG_UNUSED, {32'($urandom), 32'($urandom)});
      end
    endcase
    cfg_valid = 1'b0;
  endtask

  // One trajectory with random content. Mostly smooth ones that can pass, then ones near the
  // bounds with zero and negative steps, pure noise, and ones that walk past the horizon.
  task automatic drive_trajectory();
    int t, v, a, k, dt, n, style, r;
    n = ($urandom_range(9) == 0) ? srand(9, 16) : srand(1, 8);
    style = $urandom_range(99);
    if (style < 75) t = srand(-Q16, Q16);
    else if (style < 90) t = $urandom;
    else t = cur_horizon - srand(0, 2 * Q16);
    v = srand(2 * Q16, 15 * Q16);
    a = srand(-Q16 / 2, Q16 / 2);
    k = srand(-83886, 83886);
    dt = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (style < 50 || style >= 90) begin
        v += srand(-2048, 2048);
        a += srand(-2048, 2048);
        k += srand(-2000, 2000);
        dt = (style >= 90) ? srand(16384, 65536) : srand(8192, 32768);
      end else if (style < 75) begin
        v = srand(-2 * Q16, 45 * Q16);
        a = srand(-8 * Q16, 8 * Q16);
        k = srand(-5033164, 5033164);
        if (r < 10) dt = 0;
        else if (r < 15) dt = -srand(1, 16384);
        else dt = srand(0, 32768);
      end else begin
        v = $urandom;
        a = $urandom;
        k = $urandom;
        dt = $urandom;
      end
      send_point(mk_point(t, v, a, k, i == n - 1));
      t += dt;
    end
  endtask

  task automatic run_segment(input int quota);
    int goal;
    goal = points_sent + quota;
    while (points_sent < goal) begin
      drive_trajectory();
      // Now and then stop offering until the pipeline is empty.
      if ($urandom_range(24) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    snd_idle_pct  = 10;
    rcv_stall_pct = 56;
    hold_req      = 0;
    points_sent   = 0;
    cfg_writes    = 0;
    cur_horizon   = 8 * Q16;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: speed and accel bounds are [0,0].
    send_point(mk_point(0, 0, 0, 0, 1'b1));
    send_point(mk_point(0, Q16, -1, 0, 1'b1));
    wait_drained();

    // Full-range bounds with extreme field values; then a repeated time for zero dt.
    settle();
    load_config(SET_WIDE);
    send_point(mk_point(S_MIN, S_MAX, S_MIN, S_MAX, 1'b0));
    send_point(mk_point(S_MIN + 1, S_MIN, S_MAX, S_MIN, 1'b0));
    send_point(mk_point(S_MIN + 1, -1, 1, -1, 1'b0));
    send_point(mk_point(S_MAX, 0, 0, 0, 1'b1));
    send_point(mk_point(0, 0, 0, 0, 1'b1));

    // Ordinary bounds: horizon crossing mid-trajectory, a first point already past it,
    // values sitting exactly on the speed, accel and curvature bounds, then one step over each of them.
    settle();
    load_config(SET_TYPICAL);
    send_point(mk_point(0, 10 * Q16, 0, 167772, 1'b0));
    send_point(mk_point(6554, 10 * Q16, 6554, 167772, 1'b0));
    send_point(mk_point(11 * Q16, -5 * Q16, 0, 0, 1'b0));
    send_point(mk_point(13107, S_MAX, S_MIN, S_MAX, 1'b0));
    send_point(mk_point(19661, 0, 0, 0, 1'b1));
    send_point(mk_point(11 * Q16, S_MAX, S_MAX, S_MAX, 1'b1));
    send_point(mk_point(0, 40 * Q16, -6 * Q16, -CURV_TYP, 1'b0));
    send_point(mk_point(32768, 40 * Q16 + 1, 4 * Q16 + 1, CURV_TYP + 1, 1'b1));

    // Reversed pairs and zero bounds.
    settle();
    load_config(SET_STRICT);
    send_point(mk_point(-Q16, 7 * Q16, 0, 0, 1'b0));
    send_point(mk_point(0, 7 * Q16, 0, 0, 1'b0));
    send_point(mk_point(0, 7 * Q16, 0, 0, 1'b1));

    // Random trajectories: two segments per idling mode, new registers for each.
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      snd_idle_pct  = (seg < 2) ? 10 : (seg < 4) ? 56 : 0;
      rcv_stall_pct = (seg < 2) ? 56 : (seg < 4) ? 10 : 0;
      load_config(seg_cfg[seg]);
      if (seg == 1) begin
        // Hold the receiver off and keep offering single points so the block backs up.
        hold_req++;
        for (int i = 0; i < 10; i++)
          send_point(mk_point(srand(-Q16, Q16), srand(0, 20 * Q16), srand(-Q16, Q16),
                              srand(-83886, 83886), 1'b1));
      end
      run_segment(SEG_POINTS);
    end

    settle();
    $display("Covered %0d points and %0d register writes across directed and random phases",
             points_sent, cfg_writes);
    $display("Checked %0d verdicts (%0d passing) under sender idling, receiver stalls and hold-off",
             verdict_cnt, pass_cnt);
    if (mismatch_cnt == 0 && open_verdicts == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
design/tklc_pkg.sv
design/tklc_div.sv
design/trajectory_kinematic_limit_checker.sv
design/tklc_checker.sv
test/tklc_verdict_check.sv
test/tb_top.sv
